// ===== src/rgbcc_pkg.sv =====
// Shared types and constants of the RGB colour format converter.
`default_nettype none

package rgbcc_pkg;

    localparam int COLOR_W = 24;
    localparam int FMT_W   = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register index of accurate_mode, as seen in paddr[2].
    localparam logic REG_ACCURATE_MODE = 1'b0;

    typedef enum logic [FMT_W-1:0] {
        FMT_888  = 2'd0,
        FMT_565  = 2'd1,
        FMT_332  = 2'd2,
        FMT_NONE = 2'd3
    } fmt_t;

endpackage

`default_nettype wire

// ===== src/rgbcc_convert.sv =====
// Combinational colour conversion between RGB888, RGB565 and RGB332.
`default_nettype none

module rgbcc_convert
    import rgbcc_pkg::*;
(
    input  wire logic [COLOR_W-1:0] color,
    input  wire fmt_t               src_fmt,
    input  wire fmt_t               tgt_fmt,
    input  wire logic               accurate,
    output logic      [COLOR_W-1:0] result
);

    logic [2:0] r3;
    logic [2:0] g3;
    logic [1:0] b2;
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;

    logic [7:0] r332_8;
    logic [7:0] g332_8;
    logic [7:0] b332_8;
    logic [4:0] r332_5;
    logic [5:0] g332_6;
    logic [4:0] b332_5;
    logic [7:0] r565_8;
    logic [7:0] g565_8;
    logic [7:0] b565_8;

    assign r3 = color[7:5];
    assign g3 = color[4:2];
    assign b2 = color[1:0];
    assign r5 = color[15:11];
    assign g6 = color[10:5];
    assign b5 = color[4:0];

    // Each constant product stays within its channel width, so no carry is lost.
    always_comb
    begin
        if (accurate)
        begin
            r332_8 = 8'({5'b0, r3} * 8'd36) + 8'd3;
            g332_8 = 8'({5'b0, g3} * 8'd36) + 8'd3;
            b332_8 = 8'({6'b0, b2} * 8'd85);
            r332_5 = {r3, 2'b11};
            g332_6 = 6'({3'b0, g3} * 6'd9);
            b332_5 = 5'({3'b0, b2} * 5'd10);
            r565_8 = {r5, 3'b100};
            g565_8 = {g6, 2'b11};
            b565_8 = {b5, 3'b011};
        end
        else
        begin
            r332_8 = {r3, 5'b0};
            g332_8 = {g3, 5'b0};
            b332_8 = {b2, 6'b0};
            r332_5 = {r3, 2'b0};
            g332_6 = {g3, 3'b0};
            b332_5 = {b2, 3'b0};
            r565_8 = {r5, 3'b0};
            g565_8 = {g6, 2'b0};
            b565_8 = {b5, 3'b0};
        end
    end

    always_comb
    begin
        result = '0;
        unique case (src_fmt)
            FMT_332:
            begin
                if (tgt_fmt == FMT_888)
                    result = {r332_8, g332_8, b332_8};
                else if (tgt_fmt == FMT_565)
                    result = {8'b0, r332_5, g332_6, b332_5};
            end
            FMT_565:
            begin
                if (tgt_fmt == FMT_888)
                    result = {r565_8, g565_8, b565_8};
                else if (tgt_fmt == FMT_332)
                    result = {16'b0, color[15:13], color[10:8], color[4:3]};
            end
            FMT_888:
            begin
                if (tgt_fmt == FMT_565)
                    result = {8'b0, color[23:19], color[15:10], color[7:3]};
                else if (tgt_fmt == FMT_332)
                    result = {16'b0, color[23:21], color[15:13], color[7:6]};
            end
            default:
                result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/rgb_color_format_converter.sv =====
// Top level of the RGB colour format converter: request register, conversion, result register.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  request  | req_valid, req_ready, color_in, source_format,  | in
//           | target_format                                  |
//  response | rsp_valid, rsp_ready, color_out                | out
//  config   | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready                                         |
//
// One request enters every cycle while req_ready is high; its result is offered once it has moved
// from the request register through the converter into the result register.
// Reset empties both stages and sets accurate_mode to 1.
// A stalled response holds the result; the request stage still takes one more request.
`default_nettype none

module rgb_color_format_converter
    import rgbcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire logic [COLOR_W-1:0] color_in,
    input  wire logic [FMT_W-1:0]   source_format,
    input  wire logic [FMT_W-1:0]   target_format,

    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output logic      [COLOR_W-1:0] color_out,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic               accurate_mode_reg;
    logic               accurate_mode_next;

    logic               req_valid_reg;
    logic               req_valid_next;
    logic [COLOR_W-1:0] color_reg;
    fmt_t               src_fmt_reg;
    fmt_t               tgt_fmt_reg;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    logic [COLOR_W-1:0] color_out_reg;

    logic               take_req;
    logic               advance;
    logic [COLOR_W-1:0] converted;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        accurate_mode_next = accurate_mode_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ACCURATE_MODE))
            accurate_mode_next = pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ACCURATE_MODE)
            prdata = {{(PDATA_W-1){1'b0}}, accurate_mode_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            accurate_mode_reg <= 1'b1;
        else
            accurate_mode_reg <= accurate_mode_next;
    end

    // ------------------------------------------------------------------
    // Handshake: the result register moves on when empty or taken.
    // ------------------------------------------------------------------
    assign advance   = !rsp_valid_reg || rsp_ready;
    assign req_ready = !req_valid_reg || advance;
    assign take_req  = req_valid && req_ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (take_req)
            req_valid_next = 1'b1;
        else if (advance)
            req_valid_next = 1'b0;

        rsp_valid_next = rsp_valid_reg;
        if (advance)
            rsp_valid_next = req_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            color_reg   <= color_in;
            src_fmt_reg <= fmt_t'(source_format);
            tgt_fmt_reg <= fmt_t'(target_format);
        end
        if (advance && req_valid_reg)
            color_out_reg <= converted;
    end

    rgbcc_convert u_convert (
        .color    (color_reg),
        .src_fmt  (src_fmt_reg),
        .tgt_fmt  (tgt_fmt_reg),
        .accurate (accurate_mode_reg),
        .result   (converted)
    );

    assign rsp_valid = rsp_valid_reg;
    assign color_out = color_out_reg;

endmodule

`default_nettype wire

// ===== src/rgbcc_checker.sv =====
// Port-level checks of the RGB colour format converter and their binding.
`default_nettype none

module rgbcc_checker
    import rgbcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_ready,
    input  wire logic               rsp_valid,
    input  wire logic               rsp_ready,
    input  wire logic [COLOR_W-1:0] color_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    input  wire logic [PDATA_W-1:0] prdata,
    input  wire logic               pready
);

    // A held response keeps its colour.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(color_out))
        else $error("response changed while stalled");

    // A new response only follows a request taken through the request register and the result register.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("response without a matching request");

    // With the output empty, the block always takes a request.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request refused with an empty output");

    // A write of accurate_mode reads back on the next cycle.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_ACCURATE_MODE)
        |=> paddr[2] != REG_ACCURATE_MODE || prdata[0] == $past(pwdata[0]))
        else $error("accurate_mode read back wrong");

endmodule

bind rgb_color_format_converter rgbcc_checker u_rgbcc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .color_out (color_out),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
);

`default_nettype wire

// ===== test/tb_rgb_color_format_converter.sv =====
// Self-checking testbench of the RGB colour format converter.
`timescale 1ns / 100ps

module tb_rgb_color_format_converter;
    import rgbcc_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [PADDR_W-1:0] ADDR_ACCURATE_MODE = {REG_ACCURATE_MODE, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED        = {~REG_ACCURATE_MODE, 2'b00};

    localparam logic MODE_FAST     = 1'b0;
    localparam logic MODE_ACCURATE = 1'b1;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               req_valid     = 1'b0;
    logic               req_ready;
    logic [COLOR_W-1:0] color_in      = '0;
    logic [FMT_W-1:0]   source_format = '0;
    logic [FMT_W-1:0]   target_format = '0;
    logic               rsp_valid;
    logic               rsp_ready     = 1'b0;
    logic [COLOR_W-1:0] color_out;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [PDATA_W-1:0] pwdata        = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               model_accurate = MODE_ACCURATE;
    logic [COLOR_W-1:0] pending_colors[$];
    int                 error_count    = 0;
    int                 cycle_count    = 0;
    int                 send_idle_pct  = 0;
    int                 recv_idle_pct  = 0;
    int                 rx_hold_cycles = 0;

    rgb_color_format_converter i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .color_in      (color_in),
        .source_format (source_format),
        .target_format (target_format),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .color_out     (color_out),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Expected converted colour for one request, given the widening mode.
    function automatic logic [COLOR_W-1:0] convert_color(input logic [COLOR_W-1:0] pixel,
                                                         input fmt_t src, input fmt_t tgt,
                                                         input logic accurate);
        logic [2:0]         r3;
        logic [2:0]         g3;
        logic [1:0]         b2;
        logic [4:0]         r5;
        logic [5:0]         g6;
        logic [4:0]         b5;
        logic [COLOR_W-1:0] result;
        r3 = pixel[7:5];
        g3 = pixel[4:2];
        b2 = pixel[1:0];
        r5 = pixel[15:11];
        g6 = pixel[10:5];
        b5 = pixel[4:0];
        result = '0;
        case (src)
            FMT_332:
            begin
                if (tgt == FMT_888)
                    result = accurate ? {8'(r3 * 36 + 3), 8'(g3 * 36 + 3), 8'(b2 * 85)}
                                      : {r3, 5'b0, g3, 5'b0, b2, 6'b0};
                else if (tgt == FMT_565)
                    result = accurate ? {8'b0, 5'(r3 * 4 + 3), 6'(g3 * 9), 5'(b2 * 10)}
                                      : {8'b0, r3, 2'b0, g3, 3'b0, b2, 3'b0};
            end
            FMT_565:
            begin
                if (tgt == FMT_888)
                    result = accurate ? {8'(r5 * 8 + 4), 8'(g6 * 4 + 3), 8'(b5 * 8 + 3)}
                                      : {r5, 3'b0, g6, 2'b0, b5, 3'b0};
                else if (tgt == FMT_332)
                    result = {16'b0, pixel[15:13], pixel[10:8], pixel[4:3]};
            end
            FMT_888:
            begin
                if (tgt == FMT_565)
                    result = {8'b0, pixel[23:19], pixel[15:10], pixel[7:3]};
                else if (tgt == FMT_332)
                    result = {16'b0, pixel[23:21], pixel[15:13], pixel[7:6]};
            end
            default:
                result = '0;
        endcase
        return result;
    endfunction

    // Receiver: random stalls, or a long hold-off when one has been requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles > 0)
            begin
                rx_hold_cycles--;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        logic [COLOR_W-1:0] expected_color;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_colors.size() == 0)
            begin
                $error("color_out: no result expected, actual %h", color_out);
                error_count++;
            end
            else
            begin
                expected_color = pending_colors.pop_front();
                if (color_out !== expected_color)
                begin
                    $error("color_out: expected %h, actual %h", expected_color, color_out);
                    error_count++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [COLOR_W-1:0] pixel, input fmt_t src,
                              input fmt_t tgt);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid     <= 1'b1;
        color_in      <= pixel;
        source_format <= src;
        target_format <= tgt;
        do @(posedge clk); while (!req_ready);
        pending_colors.push_back(convert_color(pixel, src, tgt, model_accurate));
    endtask

    task automatic send_random_pixel();
        logic [COLOR_W-1:0] pixel;
        fmt_t               src;
        fmt_t               tgt;
        pixel = COLOR_W'($urandom);
        if ($urandom_range(99) < 80)
        begin
            // A genuine conversion between two different supported formats.
            src = fmt_t'($urandom_range(2));
            tgt = fmt_t'((int'(src) + $urandom_range(1, 2)) % 3);
        end
        else
        begin
            src = fmt_t'($urandom_range(3));
            tgt = fmt_t'($urandom_range(3));
        end
        // Some colours are kept clean of bits above the source format's width.
        if ($urandom_range(99) < 25)
        begin
            if (src == FMT_565)
                pixel[23:16] = '0;
            else if (src == FMT_332)
                pixel[23:8] = '0;
        end
        send_pixel(pixel, src, tgt);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_colors.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY) @(negedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        @(posedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    task automatic write_register(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_ACCURATE_MODE)
            model_accurate = data[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_accurate_mode();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ACCURATE_MODE;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== {{(PDATA_W-1){1'b0}}, model_accurate})
        begin
            $error("prdata: expected %h, actual %h",
                   {{(PDATA_W-1){1'b0}}, model_accurate}, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_accurate_mode(input logic mode);
        // Upper data bits carry noise; only bit 0 holds the mode.
        write_register(ADDR_ACCURATE_MODE, {(PDATA_W-1)'($urandom), mode});
        check_accurate_mode();
    endtask

    // Every format pair with a saturated colour, including same, unsupported and stray bits.
    task automatic test_directed_conversions();
        check_accurate_mode();
        for (int s = 0; s < 4; s++)
            for (int t = 0; t < 4; t++)
                send_pixel('1, fmt_t'(s), fmt_t'(t));
        // Black shows the additive offsets of the accurate widening.
        send_pixel('0, FMT_332, FMT_888);
        send_pixel('0, FMT_332, FMT_565);
        send_pixel('0, FMT_565, FMT_888);
        wait_for_results();
    endtask

    task automatic test_unused_register();
        write_register(ADDR_UNUSED, {PDATA_W{1'b1}} ^ PDATA_W'(model_accurate));
        check_accurate_mode();
        send_pixel(24'h0000B6, FMT_332, FMT_888);
        wait_for_results();
    endtask

    task automatic test_fast_widening();
        set_accurate_mode(MODE_FAST);
        send_pixel('1, FMT_332, FMT_888);
        send_pixel('1, FMT_332, FMT_565);
        send_pixel('1, FMT_565, FMT_888);
        send_pixel('1, FMT_565, FMT_332);
        send_pixel('1, FMT_888, FMT_565);
        send_pixel('1, FMT_888, FMT_332);
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic mode, input int count);
        set_accurate_mode(mode);
        set_idling(send_pct, recv_pct);
        repeat (count) send_random_pixel();
        wait_for_results();
    endtask

    // The receiver stops for a long stretch while requests keep coming.
    task automatic test_backpressure();
        set_accurate_mode(MODE_FAST);
        set_idling(0, 0);
        @(posedge clk);
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) send_random_pixel();
        wait_for_results();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed_conversions();
        test_unused_register();
        test_fast_widening();
        test_random_traffic(32, 58, MODE_ACCURATE, 260);
        test_random_traffic(58, 32, MODE_FAST, 260);
        test_random_traffic(0, 0, MODE_ACCURATE, 240);
        test_backpressure();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
